// ===== rtl/ico_pkg.sv =====
// Shared types and constants for the icosphere vertex generator.
// No dependencies; imported by ico_isqrt_pipe and icosphere_vertex_generator.
package ico_pkg;

  // phi in Q20, rounded to nearest
  localparam int PHI_FRAC = 20;
  localparam logic signed [31:0] PHI_Q20 = 32'sd1696632;

  // interpolated component a + b*phi times detail fits 10 signed bits
  localparam int P_W    = 10;
  // |a*2^20 + b*PHI_Q20| stays below 2^30
  localparam int M_W    = 30;
  localparam int SUM_W  = 2 * M_W + 2;
  localparam int ROOT_W = SUM_W / 2;

  // one-component corner codes: two's complement in two bits
  localparam logic [1:0] CP_ZERO = 2'b00;
  localparam logic [1:0] CP_ONE  = 2'b01;
  localparam logic [1:0] CP_NEG  = 2'b11;

  typedef struct packed {
    logic [2:0] strip;
    logic [6:0] column;
    logic [7:0] row;
  } in_item_t;

  typedef struct packed {
    logic        [15:0] vertex_index;
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic signed [15:0] z_coord;
  } out_item_t;

  typedef logic [M_W-1:0] mag_t;

  // data that rides alongside the square root pipeline
  typedef struct packed {
    logic [15:0]     vertex_index;
    logic [2:0]      neg;
    mag_t [2:0]      mag;
  } side_t;

endpackage

// ===== rtl/ico_isqrt_pipe.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on ico_pkg (SUM_W, ROOT_W, side_t).
module ico_isqrt_pipe import ico_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [SUM_W-1:0]  in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  localparam int RW = SUM_W + 1;
  localparam int NQ = ROOT_W;

  logic          valid_r [NQ];
  logic [RW-1:0] rem_r   [NQ];
  logic [RW-1:0] res_r   [NQ];
  side_t         side_r  [NQ];

  for (genvar i = 0; i < NQ; i++) begin : g_stage
    localparam logic [RW-1:0] BITV = RW'(1) << (2 * (NQ - 1 - i));
    logic          v_in;
    logic [RW-1:0] rem_in, res_in, trial, rem_nxt, res_nxt;
    side_t         side_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = RW'(in_sum);
      assign res_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign res_in  = res_r[i-1];
      assign side_in = side_r[i-1];
    end

    // one digit-by-digit step
    always_comb begin
      trial = res_in + BITV;
      if (rem_in >= trial) begin
        rem_nxt = rem_in - trial;
        res_nxt = (res_in >> 1) + BITV;
      end else begin
        rem_nxt = rem_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (adv) begin
        valid_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        res_r[i]  <= res_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_r[NQ-1];
  assign out_root  = res_r[NQ-1][ROOT_W-1:0];
  assign out_side  = side_r[NQ-1];

endmodule

// ===== rtl/icosphere_vertex_generator.sv =====
// Icosphere vertex generator: grid position in, buffer index and unit vector out.
// Depends on ico_pkg and ico_isqrt_pipe.
//
//   port group | direction | carries
//   in_*       | input     | in_item_t: strip, column, row
//   out_*      | output    | out_item_t: vertex_index, x/y/z_coord
//   cfg_*      | input     | detail (7 bits), always ready
//
// One vertex per cycle while the output is not stalled. The pipeline is 7 front
// stages, ROOT_W (31) square root stages and COORD_FRAC_BITS+1 division
// stages, then the output register.
// The whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage, so nothing is lost or repeated.
// Reset clears the valid bits and sets detail to 1.
module icosphere_vertex_generator import ico_pkg::*; #(
  parameter int MAX_DETAIL      = 64,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_detail
);

  localparam int QB    = COORD_FRAC_BITS + 1;
  localparam int DIV_W = ROOT_W + QB;

  // corner tables, components packed {x, y, z}: value = a + b*phi
  function automatic logic [5:0] corner_a(input logic [3:0] c);
    unique case (c)
      4'd0:    return {CP_ZERO, CP_ONE,  CP_ZERO};
      4'd1:    return {CP_ZERO, CP_NEG,  CP_ZERO};
      4'd2:    return {CP_ZERO, CP_ZERO, CP_ONE };
      4'd3:    return {CP_ONE,  CP_ZERO, CP_ZERO};
      4'd4:    return {CP_NEG,  CP_ZERO, CP_ZERO};
      4'd5:    return {CP_ZERO, CP_ZERO, CP_ONE };
      4'd6:    return {CP_NEG,  CP_ZERO, CP_ZERO};
      4'd7:    return {CP_ONE,  CP_ZERO, CP_ZERO};
      4'd8:    return {CP_ZERO, CP_ZERO, CP_NEG };
      4'd9:    return {CP_ZERO, CP_ONE,  CP_ZERO};
      4'd10:   return {CP_ZERO, CP_ZERO, CP_NEG };
      4'd11:   return {CP_ZERO, CP_NEG,  CP_ZERO};
      default: return {CP_ZERO, CP_ZERO, CP_ZERO};
    endcase
  endfunction

  function automatic logic [5:0] corner_b(input logic [3:0] c);
    unique case (c)
      4'd0:    return {CP_ZERO, CP_ZERO, CP_ONE };
      4'd1:    return {CP_ZERO, CP_ZERO, CP_ONE };
      4'd2:    return {CP_ONE,  CP_ZERO, CP_ZERO};
      4'd3:    return {CP_ZERO, CP_ONE,  CP_ZERO};
      4'd4:    return {CP_ZERO, CP_ONE,  CP_ZERO};
      4'd5:    return {CP_NEG,  CP_ZERO, CP_ZERO};
      4'd6:    return {CP_ZERO, CP_NEG,  CP_ZERO};
      4'd7:    return {CP_ZERO, CP_NEG,  CP_ZERO};
      4'd8:    return {CP_ONE,  CP_ZERO, CP_ZERO};
      4'd9:    return {CP_ZERO, CP_ZERO, CP_NEG };
      4'd10:   return {CP_NEG,  CP_ZERO, CP_ZERO};
      4'd11:   return {CP_ZERO, CP_ZERO, CP_NEG };
      default: return {CP_ZERO, CP_ZERO, CP_ZERO};
    endcase
  endfunction

  // c times a small coefficient in -2..2
  function automatic logic signed [P_W-1:0] scale(input logic [6:0] c,
                                                  input logic signed [2:0] e);
    logic signed [P_W-1:0] cv;
    cv = $signed(P_W'(c));
    unique case (e)
      3'sd1:   return cv;
      3'sd2:   return cv <<< 1;
      -3'sd1:  return -cv;
      -3'sd2:  return -(cv <<< 1);
      default: return '0;
    endcase
  endfunction

  // d*v0 + c1*(v1-v0) + c2*(v2-v0) for one component
  function automatic logic signed [P_W-1:0] weigh(input logic [6:0] d,
      input logic [6:0] c1, input logic [6:0] c2,
      input logic [1:0] v0, input logic [1:0] v1, input logic [1:0] v2);
    logic signed [2:0] e0, e1, e2;
    e0 = $signed({v0[1], v0});
    e1 = $signed({v1[1], v1}) - e0;
    e2 = $signed({v2[1], v2}) - e0;
    return scale(d, e0) + scale(c1, e1) + scale(c2, e2);
  endfunction

  // ---------------- configuration ----------------
  logic [6:0] detail_r;
  logic [6:0] detail_nxt;

  assign cfg_ready = 1'b1;

  // store the clamped value; it is only used clamped
  always_comb begin
    priority if (cfg_detail == 7'd0) begin
      detail_nxt = 7'd1;
    end else if (cfg_detail > 7'(MAX_DETAIL)) begin
      detail_nxt = 7'(MAX_DETAIL);
    end else begin
      detail_nxt = cfg_detail;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      detail_r <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      detail_r <= detail_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // ---------------- stage 1: wrap and clamp ----------------
  logic       s1_valid_r;
  logic [2:0] s1_strip_r;
  logic [6:0] s1_col_r;
  logic [7:0] s1_row_r;
  logic [7:0] row_max;

  assign row_max = 8'(3 * detail_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_strip_r <= (in_data.strip >= 3'd5) ? in_data.strip - 3'd5 : in_data.strip;
      s1_col_r   <= (in_data.column > detail_r) ? detail_r : in_data.column;
      s1_row_r   <= (in_data.row > row_max) ? row_max : in_data.row;
    end
  end

  // ---------------- stage 2: seam move and face select ----------------
  logic       s2_valid_r;
  logic [7:0] s2_row_r;
  logic [8:0] s2_lin_r;
  logic [3:0] s2_i0_r, s2_i1_r, s2_i2_r;
  logic [6:0] s2_c1_r, s2_c2_r;

  logic [8:0] lin_nxt;
  logic [7:0] two_d;
  logic       seam;
  logic [2:0] strip_s, next_s;
  logic [6:0] col_s;
  logic [3:0] i0_nxt, i1_nxt, i2_nxt;
  logic [6:0] c1_nxt, c2_nxt;

  always_comb begin
    lin_nxt = 9'(s1_col_r) + 9'(9'(detail_r) * 9'(s1_strip_r));
    two_d   = {1'b0, detail_r} << 1;
    seam    = (s1_row_r >= two_d) && (s1_col_r == 7'd0);
    strip_s = s1_strip_r;
    col_s   = s1_col_r;
    if (seam) begin
      strip_s = (s1_strip_r == 3'd0) ? 3'd4 : s1_strip_r - 3'd1;
      col_s   = detail_r;
    end
    next_s = (strip_s == 3'd4) ? 3'd0 : strip_s + 3'd1;

    priority if (s1_row_r <= 8'(detail_r)) begin
      i0_nxt = 4'd1 + 4'(strip_s);
      i1_nxt = 4'd0;
      i2_nxt = 4'd1 + 4'(next_s);
      c1_nxt = 7'(8'(detail_r) - s1_row_r);
      c2_nxt = col_s;
    end else if (s1_row_r >= two_d) begin
      i0_nxt = 4'd6 + 4'(next_s);
      i1_nxt = 4'd11;
      i2_nxt = 4'd6 + 4'(strip_s);
      c1_nxt = 7'(s1_row_r - two_d);
      c2_nxt = detail_r - col_s;
    end else if (9'(s1_row_r) <= 9'(detail_r) + 9'(col_s)) begin
      i0_nxt = 4'd1 + 4'(next_s);
      i1_nxt = 4'd6 + 4'(next_s);
      i2_nxt = 4'd1 + 4'(strip_s);
      c1_nxt = 7'(s1_row_r - 8'(detail_r));
      c2_nxt = detail_r - col_s;
    end else begin
      i0_nxt = 4'd6 + 4'(strip_s);
      i1_nxt = 4'd6 + 4'(next_s);
      i2_nxt = 4'd1 + 4'(strip_s);
      c1_nxt = col_s;
      c2_nxt = 7'(two_d - s1_row_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_row_r <= s1_row_r;
      s2_lin_r <= lin_nxt;
      s2_i0_r  <= i0_nxt;
      s2_i1_r  <= i1_nxt;
      s2_i2_r  <= i2_nxt;
      s2_c1_r  <= c1_nxt;
      s2_c2_r  <= c2_nxt;
    end
  end

  // ---------------- stage 3: index and interpolation ----------------
  logic                  s3_valid_r;
  logic [15:0]           s3_idx_r;
  logic signed [P_W-1:0] s3_pa_r [3];
  logic signed [P_W-1:0] s3_pb_r [3];

  logic [5:0]  a0, a1, a2, b0, b1, b2;
  logic [7:0]  span;
  logic [16:0] idx_full;

  assign a0       = corner_a(s2_i0_r);
  assign a1       = corner_a(s2_i1_r);
  assign a2       = corner_a(s2_i2_r);
  assign b0       = corner_b(s2_i0_r);
  assign b1       = corner_b(s2_i1_r);
  assign b2       = corner_b(s2_i2_r);
  assign span     = 8'(3 * detail_r + 1);
  assign idx_full = 17'(s2_row_r) + 17'(span) * 17'(s2_lin_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_weigh
    always_ff @(posedge clk) begin
      if (adv) begin
        s3_pa_r[k] <= weigh(detail_r, s2_c1_r, s2_c2_r,
                            a0[5-2*k -: 2], a1[5-2*k -: 2], a2[5-2*k -: 2]);
        s3_pb_r[k] <= weigh(detail_r, s2_c1_r, s2_c2_r,
                            b0[5-2*k -: 2], b1[5-2*k -: 2], b2[5-2*k -: 2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_idx_r <= idx_full[15:0];
    end
  end

  // ---------------- stage 4: a*2^20 + b*phi ----------------
  logic               s4_valid_r;
  logic [15:0]        s4_idx_r;
  logic signed [31:0] s4_s_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_idx_r <= s3_idx_r;
      for (int k = 0; k < 3; k++) begin
        s4_s_r[k] <= (32'(s3_pa_r[k]) <<< PHI_FRAC) + 32'(s3_pb_r[k]) * PHI_Q20;
      end
    end
  end

  // ---------------- stage 5: magnitude and sign ----------------
  logic        s5_valid_r;
  logic [15:0] s5_idx_r;
  logic [2:0]  s5_neg_r;
  mag_t        s5_mag_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_idx_r <= s4_idx_r;
      for (int k = 0; k < 3; k++) begin
        s5_neg_r[k] <= s4_s_r[k][31];
        s5_mag_r[k] <= M_W'(s4_s_r[k][31] ? -s4_s_r[k] : s4_s_r[k]);
      end
    end
  end

  // ---------------- stage 6: squares ----------------
  logic               s6_valid_r;
  logic [15:0]        s6_idx_r;
  logic [2:0]         s6_neg_r;
  mag_t               s6_mag_r [3];
  logic [2*M_W-1:0]   s6_sq_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_idx_r <= s5_idx_r;
      s6_neg_r <= s5_neg_r;
      for (int k = 0; k < 3; k++) begin
        s6_mag_r[k] <= s5_mag_r[k];
        s6_sq_r[k]  <= (2*M_W)'(s5_mag_r[k]) * (2*M_W)'(s5_mag_r[k]);
      end
    end
  end

  // ---------------- stage 7: sum of squares ----------------
  logic             s7_valid_r;
  logic [SUM_W-1:0] s7_sum_r;
  side_t            s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
    end else if (adv) begin
      s7_valid_r <= s6_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_sum_r                <= SUM_W'(s6_sq_r[0]) + SUM_W'(s6_sq_r[1])
                                 + SUM_W'(s6_sq_r[2]);
      s7_side_r.vertex_index  <= s6_idx_r;
      s7_side_r.neg           <= s6_neg_r;
      s7_side_r.mag[0]        <= s6_mag_r[0];
      s7_side_r.mag[1]        <= s6_mag_r[1];
      s7_side_r.mag[2]        <= s6_mag_r[2];
    end
  end

  // ---------------- square root ----------------
  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;
  side_t             rt_side;

  ico_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s7_valid_r),
    .in_sum    (s7_sum_r),
    .in_side   (s7_side_r),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  // ---------------- division: one quotient bit per stage ----------------
  logic              dv_valid_r [QB];
  logic [15:0]       dv_idx_r   [QB];
  logic [2:0]        dv_neg_r   [QB];
  logic [ROOT_W-1:0] dv_n_r     [QB];
  logic [DIV_W-1:0]  dv_rem_r   [QB][3];
  logic [QB-1:0]     dv_q_r     [QB][3];

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic              v_in;
    logic [15:0]       idx_in;
    logic [2:0]        neg_in;
    logic [ROOT_W-1:0] n_in;
    logic [DIV_W-1:0]  rem_in [3];
    logic [QB-1:0]     q_in   [3];
    logic [DIV_W-1:0]  dsh;
    logic [DIV_W-1:0]  rem_nxt [3];
    logic [QB-1:0]     q_nxt   [3];

    if (j == 0) begin : g_first
      assign v_in   = rt_valid;
      assign idx_in = rt_side.vertex_index;
      assign neg_in = rt_side.neg;
      assign n_in   = rt_root;
      for (genvar k = 0; k < 3; k++) begin : g_k
        // (m << F) + n/2 gives round half up on the quotient
        assign rem_in[k] = (DIV_W'(rt_side.mag[k]) << COORD_FRAC_BITS)
                           + DIV_W'(rt_root >> 1);
        assign q_in[k]   = '0;
      end
    end else begin : g_next
      assign v_in   = dv_valid_r[j-1];
      assign idx_in = dv_idx_r[j-1];
      assign neg_in = dv_neg_r[j-1];
      assign n_in   = dv_n_r[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_k
        assign rem_in[k] = dv_rem_r[j-1][k];
        assign q_in[k]   = dv_q_r[j-1][k];
      end
    end

    assign dsh = DIV_W'(n_in) << (QB - 1 - j);

    // restoring step for all three components
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        rem_nxt[k] = rem_in[k];
        q_nxt[k]   = q_in[k];
        if (rem_in[k] >= dsh) begin
          rem_nxt[k]          = rem_in[k] - dsh;
          q_nxt[k][QB-1-j]    = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[j] <= 1'b0;
      end else if (adv) begin
        dv_valid_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_idx_r[j] <= idx_in;
        dv_neg_r[j] <= neg_in;
        dv_n_r[j]   <= n_in;
        for (int k = 0; k < 3; k++) begin
          dv_rem_r[j][k] <= rem_nxt[k];
          dv_q_r[j][k]   <= q_nxt[k];
        end
      end
    end
  end

  // ---------------- output register ----------------
  localparam logic [QB-1:0] ONE_Q = QB'(1) << COORD_FRAC_BITS;

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic [15:0] coord_nxt [3];

  always_comb begin
    logic [QB-1:0] q;
    logic [31:0]   qe;
    for (int k = 0; k < 3; k++) begin
      q = dv_q_r[QB-1][k];
      if (dv_n_r[QB-1] == '0) begin
        q = '0;
      end else if (q > ONE_Q) begin
        q = ONE_Q;
      end
      qe = 32'(q);
      if (dv_neg_r[QB-1][k]) begin
        qe = -qe;
      end
      coord_nxt[k] = qe[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.vertex_index <= dv_idx_r[QB-1];
      out_data_r.x_coord      <= $signed(coord_nxt[0]);
      out_data_r.y_coord      <= $signed(coord_nxt[1]);
      out_data_r.z_coord      <= $signed(coord_nxt[2]);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  // stored detail is always the clamped value
  a_detail_range: assert property (@(posedge clk) disable iff (!rst_n)
    detail_r != 7'd0 && detail_r <= 7'(MAX_DETAIL))
    else $error("detail register out of range");

  // no component can exceed the norm
  a_mag_le_root: assert property (@(posedge clk) disable iff (!rst_n)
    rt_valid |-> (ROOT_W'(rt_side.mag[0]) <= rt_root)
              && (ROOT_W'(rt_side.mag[1]) <= rt_root)
              && (ROOT_W'(rt_side.mag[2]) <= rt_root))
    else $error("component magnitude above square root");

  // quotient never goes above one
  a_quot_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid_r[QB-1] |-> (dv_q_r[QB-1][0] <= ONE_Q) && (dv_q_r[QB-1][1] <= ONE_Q)
                      && (dv_q_r[QB-1][2] <= ONE_Q))
    else $error("coordinate quotient above one");

  // a stall freezes the front of the pipeline
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(s1_valid_r) && $stable(s7_valid_r))
    else $error("pipeline moved during stall");

endmodule
